>>> rtl/core/tsb_pkg.sv
// ----------------------------------------------------------------------------
// Timer slot bank package
// Shared constants, request and result payloads, and memory access types.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [31:0] IDLE_EXPIRY = 32'hFFFF_FFFF;
  localparam logic [15:0] SLEEP_RESET = 16'd500;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_EXTEND = 3'd2;
  localparam logic [2:0] CMD_STOP   = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;
  localparam logic [2:0] CMD_SCAN   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_UNINIT  = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic        handle_held;
    logic [3:0]  slot_select;
    logic [31:0] duration_ms;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]  slot_index;
    logic [1:0]  status;
    logic        running;
    logic        expired;
    logic [15:0] sleep_ms;
  } rsp_t;

  typedef struct packed {
    logic [31:0] expiry;
    logic        waiting;
  } entry_t;

  typedef struct packed {
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    entry_t        wr_data;
  } mem_req_t;

endpackage

>>> rtl/core/tsb_req_if.sv
// ----------------------------------------------------------------------------
// Timer slot bank request channel
// Valid and ready handshake carrying one command request.
// ----------------------------------------------------------------------------
interface tsb_req_if import tsb_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/core/tsb_rsp_if.sv
// ----------------------------------------------------------------------------
// Timer slot bank result channel
// Valid and ready handshake carrying one command result.
// ----------------------------------------------------------------------------
interface tsb_rsp_if import tsb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/core/software_timer_slot_bank.sv
// ----------------------------------------------------------------------------
// Software timer slot bank
// Timer slots with allocation, start, extend, stop, query and a scan that
// returns the least remaining time, capped by a programmable sleep limit.
// ----------------------------------------------------------------------------
// Init, start, extend, stop and query pass through the read, modify and done states
// before the result is registered; with no free slot, a query without a handle or an
// unused code they skip the modify state. The next request is taken back in idle.
// A scan reads one slot per cycle and gives its result once every slot has been
// read. A waiting result only stalls a later one.
// Reset clears the enable and entry valid bits at once and sets the sleep limit to 500.
module software_timer_slot_bank import tsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  tsb_req_if.sink     req,
  tsb_rsp_if.source   rsp
);

  mem_req_t mem_req;
  entry_t   rd_data;

  tsb_slot_mem u_slot_mem (
    .clk     (clk),
    .rst     (rst),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  tsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

endmodule

>>> rtl/core/tsb_slot_mem.sv
// ----------------------------------------------------------------------------
// Timer slot memory
// One entry per slot with expiry and waiting mark, one read and one write
// port, registered read data. Entries never written read as zero.
// ----------------------------------------------------------------------------
module tsb_slot_mem import tsb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t mem_req,
  output entry_t   rd_data
);

  entry_t                  mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   written;
  entry_t                  rd_q;
  logic                    rd_written;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_q <= mem[mem_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (mem_req.wr_en) begin
        written[mem_req.wr_addr] <= 1'b1;
      end
      if (mem_req.rd_en) begin
        rd_written <= written[mem_req.rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

>>> rtl/core/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// Timer slot bank controller
// Sequencer for allocation, read-modify-write of one slot, query and the
// next-expiry scan, with the enable bits, the sleep limit and the result
// register.
// ----------------------------------------------------------------------------
module tsb_ctrl import tsb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  tsb_req_if.sink        req,
  tsb_rsp_if.source      rsp,
  output mem_req_t       mem_req,
  input  entry_t         rd_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_MODIFY = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                state;
  req_t                  cmd_q;
  logic [SW-1:0]         slot;
  logic                  alloc;
  rsp_t                  res;
  rsp_t                  rsp_q;
  logic                  out_valid;
  logic [15:0]           max_sleep_ms;
  logic [SLOT_COUNT-1:0] enabled;
  logic [SW-1:0]         rd_idx;
  logic                  rd_done;
  logic [SW-1:0]         dat_idx;
  logic                  dat_vld;
  logic [15:0]           best;

  logic                  free_found;
  logic [SW-1:0]         free_idx;
  logic                  handle_ok;
  logic                  slot_cmd;
  logic                  pick_ok;
  logic [SW-1:0]         pick_slot;
  logic [31:0]           new_expiry;
  logic [32:0]           diff;
  logic [31:0]           rem;
  logic                  eligible;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!enabled[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign handle_ok = cmd_q.handle_held && (32'(cmd_q.slot_select) < SLOT_COUNT);
  assign slot_cmd  = (cmd_q.command <= CMD_STOP);
  assign pick_ok   = handle_ok || free_found;
  assign pick_slot = handle_ok ? SW'(cmd_q.slot_select) : free_idx;

  always_comb begin
    case (cmd_q.command)
      CMD_START:  new_expiry = cmd_q.now_ms + cmd_q.duration_ms;
      CMD_EXTEND: new_expiry = (alloc ? IDLE_EXPIRY : rd_data.expiry) + cmd_q.duration_ms;
      default:    new_expiry = IDLE_EXPIRY;
    endcase
  end

  assign diff     = {1'b0, rd_data.expiry} - {1'b0, cmd_q.now_ms};
  assign rem      = diff[32] ? 32'd0 : diff[31:0];
  assign eligible = dat_vld && enabled[dat_idx] && !rd_data.waiting &&
                    (rd_data.expiry != IDLE_EXPIRY);

  always_comb begin
    mem_req = '0;
    case (state)
      S_READ: begin
        if (slot_cmd && pick_ok) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = pick_slot;
        end else if (cmd_q.command == CMD_QUERY && handle_ok) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = SW'(cmd_q.slot_select);
        end
      end
      S_MODIFY: begin
        if (slot_cmd) begin
          mem_req.wr_en           = 1'b1;
          mem_req.wr_addr         = slot;
          mem_req.wr_data.expiry  = new_expiry;
          mem_req.wr_data.waiting = 1'b0;
        end
      end
      S_SCAN: begin
        mem_req.rd_en           = !rd_done;
        mem_req.rd_addr         = rd_idx;
        mem_req.wr_en           = eligible;
        mem_req.wr_addr         = dat_idx;
        mem_req.wr_data.expiry  = rd_data.expiry;
        mem_req.wr_data.waiting = (rem == 32'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enabled      <= '0;
      out_valid    <= 1'b0;
      max_sleep_ms <= SLEEP_RESET;
    end else begin
      if (cfg_we) begin
        max_sleep_ms <= cfg_wdata;
      end
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.payload;
            res   <= '0;
            if (req.payload.command == CMD_SCAN) begin
              rd_idx  <= '0;
              rd_done <= 1'b0;
              dat_vld <= 1'b0;
              best    <= max_sleep_ms;
              state   <= S_SCAN;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (slot_cmd) begin
            if (pick_ok) begin
              slot  <= pick_slot;
              alloc <= !handle_ok;
              if (!handle_ok) begin
                enabled[pick_slot] <= 1'b1;
              end
              state <= S_MODIFY;
            end else begin
              res.status <= ST_NO_FREE;
              state      <= S_DONE;
            end
          end else if (cmd_q.command == CMD_QUERY) begin
            if (handle_ok) begin
              slot  <= SW'(cmd_q.slot_select);
              alloc <= 1'b0;
              state <= S_MODIFY;
            end else begin
              res.status <= ST_UNINIT;
              state      <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_MODIFY: begin
          res.slot_index <= 4'(slot);
          res.status     <= ST_OK;
          if (cmd_q.command == CMD_QUERY) begin
            res.running <= (rd_data.expiry != IDLE_EXPIRY);
            res.expired <= (cmd_q.now_ms >= rd_data.expiry);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          dat_vld <= !rd_done;
          dat_idx <= rd_idx;
          if (!rd_done) begin
            rd_idx <= rd_idx + 1'b1;
            if (rd_idx == SW'(SLOT_COUNT - 1)) begin
              rd_done <= 1'b1;
            end
          end
          if (eligible && (rem[31:16] == 16'd0) && (rem[15:0] < best)) begin
            best <= rem[15:0];
          end
          if (rd_done && !dat_vld) begin
            res.sleep_ms <= best;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            rsp_q     <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready   = (state == S_IDLE) && !rst;
  assign rsp.valid   = out_valid;
  assign rsp.payload = rsp_q;

endmodule
